>>> rtl/lrw_pkg.sv
// shared types, widths and helpers for the linear resample weight generator
package lrw_pkg;

  localparam int MAX_LENGTH = 4096;
  localparam int FRAC_BITS  = 16;

  localparam int IDX_W  = $clog2(MAX_LENGTH);
  localparam int LEN_W  = IDX_W + 1;
  localparam int DEN_W  = LEN_W + 1;
  localparam int NUM_W  = 2 * IDX_W + 1;
  localparam int PROD_W = 2 * LEN_W;
  localparam int TD_W   = IDX_W + DEN_W;
  localparam int Q_W    = IDX_W + FRAC_BITS;
  localparam int NW_W   = FRAC_BITS + 1;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_SOURCE_LENGTH = 2'd0,
    REG_TARGET_LENGTH = 2'd1,
    REG_CORNER_ALIGNED = 2'd2,
    REG_NONE = 2'd3
  } lrw_reg_t;

  typedef struct packed {
    logic             valid;
    logic             clamp;
    logic [IDX_W-1:0] top;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   work;
  } lrw_div_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (v > LEN_W'(MAX_LENGTH)) begin
      r = LEN_W'(MAX_LENGTH);
    end
    return r;
  endfunction

endpackage

>>> rtl/lrw_front.sv
// coordinate setup: numerator, denominator and clamp test for the divider chain
module lrw_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      req_valid,
  input  logic [lrw_pkg::IDX_W-1:0] req_index,
  input  logic [lrw_pkg::LEN_W-1:0] src_len,
  input  logic [lrw_pkg::LEN_W-1:0] tgt_len,
  input  logic                      corner,
  output lrw_pkg::lrw_div_t         div_out
);
  import lrw_pkg::*;

  logic              v1_r;
  logic              corner1_r;
  logic              tgt_gt1_r;
  logic [LEN_W-1:0]  tgt1_r;
  logic [IDX_W-1:0]  top1_r;
  logic [DEN_W-1:0]  den1_r;
  logic [PROD_W-1:0] prod1_r;
  logic [TD_W-1:0]   topden1_r;

  logic [LEN_W-1:0]  mul_a;
  logic [LEN_W-1:0]  mul_b;
  logic [IDX_W-1:0]  top_c;
  logic [DEN_W-1:0]  den_c;
  logic              tgt_gt1_c;

  logic [NUM_W-1:0]  num_c;
  logic              clamp_c;
  lrw_div_t          div_r;

  always_comb begin
    top_c     = IDX_W'(src_len - LEN_W'(1));
    tgt_gt1_c = (tgt_len > LEN_W'(1));
    if (corner) begin
      mul_a = {1'b0, req_index};
      mul_b = {1'b0, top_c};
      den_c = tgt_gt1_c ? DEN_W'(tgt_len - LEN_W'(1)) : DEN_W'(1);
    end else begin
      mul_a = {req_index, 1'b1};
      mul_b = src_len;
      den_c = {tgt_len, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    corner1_r <= corner;
    tgt_gt1_r <= tgt_gt1_c;
    tgt1_r    <= tgt_len;
    top1_r    <= top_c;
    den1_r    <= den_c;
    prod1_r   <= PROD_W'(mul_a) * PROD_W'(mul_b);
    topden1_r <= TD_W'(top_c) * TD_W'(den_c);
  end

  always_comb begin
    if (corner1_r) begin
      num_c = tgt_gt1_r ? NUM_W'(prod1_r) : '0;
    end else if (prod1_r > PROD_W'(tgt1_r)) begin
      num_c = NUM_W'(prod1_r - PROD_W'(tgt1_r));
    end else begin
      num_c = '0;
    end
    clamp_c = (TD_W'(num_c) >= topden1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r.valid <= 1'b0;
    end else begin
      div_r.valid <= v1_r;
    end
    div_r.clamp <= clamp_c;
    div_r.top   <= top1_r;
    div_r.den   <= den1_r;
    div_r.rem   <= DEN_W'(num_c[NUM_W-1:IDX_W]);
    div_r.work  <= {num_c[IDX_W-1:0], {FRAC_BITS{1'b0}}};
  end

  assign div_out = div_r;

endmodule

>>> rtl/lrw_cell.sv
// one restoring-division cell: produces one quotient bit per request
module lrw_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  lrw_pkg::lrw_div_t d_in,
  output lrw_pkg::lrw_div_t d_out
);
  import lrw_pkg::*;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             qbit;
  logic [DEN_W-1:0] rem_c;
  lrw_div_t         d_r;

  always_comb begin
    rem_sh = {d_in.rem, d_in.work[Q_W-1]};
    diff   = rem_sh - {1'b0, d_in.den};
    qbit   = (rem_sh >= {1'b0, d_in.den});
    rem_c  = qbit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else begin
      d_r.valid <= d_in.valid;
    end
    d_r.clamp <= d_in.clamp;
    d_r.top   <= d_in.top;
    d_r.den   <= d_in.den;
    d_r.rem   <= rem_c;
    d_r.work  <= {d_in.work[Q_W-2:0], qbit};
  end

  assign d_out = d_r;

endmodule

>>> rtl/linear_resample_weight_generator_core.sv
// top level: config registers, setup stages, divider cell chain and result register
// One request is taken every clock cycle (busy stays low) and its result appears
// on the out_ ports with out_valid high for one cycle, after passing through
// two setup stages (multiply, then subtract and clamp test), a chain of 28
// division cells that each resolve one quotient bit (12 index bits plus 16
// fraction bits), and the result register. The receiver cannot stall the
// block and none is needed. Registers are at byte addresses 0 (source_length),
// 4 (target_length) and 8 (corner_aligned); write them only while no request
// is in flight. Lengths of 0 act as 1 and lengths above 4096 act as 4096.
module linear_resample_weight_generator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lrw_pkg::IDX_W-1:0]     in_target_index,
  output logic                          out_valid,
  output logic [lrw_pkg::IDX_W-1:0]     out_near_index,
  output logic [lrw_pkg::IDX_W-1:0]     out_far_index,
  output logic [lrw_pkg::NW_W-1:0]      out_near_weight,
  output logic [lrw_pkg::FRAC_BITS-1:0] out_far_weight,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrw_pkg::ADDR_W-1:0]    paddr,
  input  logic [lrw_pkg::DATA_W-1:0]    pwdata,
  output logic [lrw_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import lrw_pkg::*;

  logic [LEN_W-1:0] source_length_r;
  logic [LEN_W-1:0] target_length_r;
  logic             corner_aligned_r;
  lrw_reg_t         reg_sel;
  logic             wr_en;

  lrw_div_t         chain [0:Q_W];

  logic             valid_r;
  logic [IDX_W-1:0] near_r;
  logic [IDX_W-1:0] far_r;
  logic [NW_W-1:0]  nw_r;
  logic [FRAC_BITS-1:0] fw_r;

  logic [IDX_W-1:0]     near_nxt;
  logic [IDX_W-1:0]     far_nxt;
  logic [FRAC_BITS-1:0] frac_nxt;
  logic [IDX_W:0]       near_inc;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    case (paddr[ADDR_W-1:2])
      2'd0:    reg_sel = REG_SOURCE_LENGTH;
      2'd1:    reg_sel = REG_TARGET_LENGTH;
      2'd2:    reg_sel = REG_CORNER_ALIGNED;
      default: reg_sel = REG_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_length_r  <= LEN_W'(1);
      target_length_r  <= LEN_W'(1);
      corner_aligned_r <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_SOURCE_LENGTH:  source_length_r  <= pwdata[LEN_W-1:0];
        REG_TARGET_LENGTH:  target_length_r  <= pwdata[LEN_W-1:0];
        REG_CORNER_ALIGNED: corner_aligned_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SOURCE_LENGTH:  prdata = DATA_W'(source_length_r);
      REG_TARGET_LENGTH:  prdata = DATA_W'(target_length_r);
      REG_CORNER_ALIGNED: prdata = DATA_W'(corner_aligned_r);
      default:            prdata = '0;
    endcase
  end

  lrw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (start & ~busy),
    .req_index (in_target_index),
    .src_len   (eff_len(source_length_r)),
    .tgt_len   (eff_len(target_length_r)),
    .corner    (corner_aligned_r),
    .div_out   (chain[0])
  );

  for (genvar i = 0; i < Q_W; i++) begin : g_cell
    lrw_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  always_comb begin
    if (chain[Q_W].clamp) begin
      near_nxt = chain[Q_W].top;
      frac_nxt = '0;
    end else begin
      near_nxt = chain[Q_W].work[Q_W-1:FRAC_BITS];
      frac_nxt = chain[Q_W].work[FRAC_BITS-1:0];
    end
    near_inc = {1'b0, near_nxt} + (IDX_W+1)'(1);
    far_nxt  = (near_inc < {1'b0, chain[Q_W].top}) ? near_inc[IDX_W-1:0]
                                                   : chain[Q_W].top;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= chain[Q_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    near_r <= near_nxt;
    far_r  <= far_nxt;
    fw_r   <= frac_nxt;
    nw_r   <= (NW_W'(1) << FRAC_BITS) - NW_W'(frac_nxt);
  end

  assign out_valid       = valid_r;
  assign out_near_index  = near_r;
  assign out_far_index   = far_r;
  assign out_near_weight = nw_r;
  assign out_far_weight  = fw_r;

endmodule

>>> tb/sv/testbench.sv
// testbench for the linear resample weight generator: directed table, random phases, predictor
`timescale 1ns / 1ps

module testbench;
  import lrw_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]     near_index;
    logic [IDX_W-1:0]     far_index;
    logic [NW_W-1:0]      near_weight;
    logic [FRAC_BITS-1:0] far_weight;
  } weights_t;

  typedef struct {
    logic [DATA_W-1:0] src;
    logic [DATA_W-1:0] tgt;
    logic [DATA_W-1:0] corner;
    logic [IDX_W-1:0]  index;
    bit                literal;
    weights_t          want;
  } vector_t;

  localparam int NUM_ROWS = 25;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 45;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [IDX_W-1:0]     in_target_index = '0;
  logic                 out_valid;
  logic [IDX_W-1:0]     out_near_index;
  logic [IDX_W-1:0]     out_far_index;
  logic [NW_W-1:0]      out_near_weight;
  logic [FRAC_BITS-1:0] out_far_weight;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  logic [LEN_W-1:0] src_len = LEN_W'(1);
  logic [LEN_W-1:0] tgt_len = LEN_W'(1);
  logic             corner_mode = 1'b0;

  bit       use_literal = 1'b0;
  weights_t literal_weights = '0;
  weights_t expected_weights[$];
  int       errors = 0;

  int idle_pct_by_phase[4] = '{0, 72, 0, 36};

  vector_t directed_rows[NUM_ROWS] = '{
    '{1, 1, 0, 0, 1'b1, '{12'd0, 12'd0, 17'd65536, 16'd0}},
    '{1, 1, 0, 4095, 1'b1, '{12'd0, 12'd0, 17'd65536, 16'd0}},
    '{0, 0, 1, 7, 1'b1, '{12'd0, 12'd0, 17'd65536, 16'd0}},
    '{8, 1, 1, 0, 1'b1, '{12'd0, 12'd1, 17'd65536, 16'd0}},
    '{8, 1, 1, 4095, 1'b1, '{12'd0, 12'd1, 17'd65536, 16'd0}},
    '{4, 8, 0, 0, 1'b1, '{12'd0, 12'd1, 17'd65536, 16'd0}},
    '{4, 8, 0, 7, 1'b1, '{12'd3, 12'd3, 17'd65536, 16'd0}},
    '{4, 8, 0, 3, 1'b0, '0},
    '{4, 8, 0, 5, 1'b0, '0},
    '{5, 3, 1, 1, 1'b0, '0},
    '{5, 3, 1, 2, 1'b1, '{12'd4, 12'd4, 17'd65536, 16'd0}},
    '{8191, 8191, 0, 4095, 1'b1, '{12'd4095, 12'd4095, 17'd65536, 16'd0}},
    '{8191, 8191, 0, 0, 1'b1, '{12'd0, 12'd1, 17'd65536, 16'd0}},
    '{8191, 8191, 0, 2048, 1'b0, '0},
    '{4097, 3, 1, 1, 1'b0, '0},
    '{4097, 3, 1, 2, 1'b1, '{12'd4095, 12'd4095, 17'd65536, 16'd0}},
    '{16, 4, 1, 4095, 1'b1, '{12'd15, 12'd15, 17'd65536, 16'd0}},
    '{16, 4, 1, 100, 1'b1, '{12'd15, 12'd15, 17'd65536, 16'd0}},
    '{3, 4096, 1, 1, 1'b0, '0},
    '{3, 4096, 1, 4094, 1'b0, '0},
    '{2, 3, 0, 1, 1'b0, '0},
    '{4096, 1, 0, 0, 1'b0, '0},
    '{1, 4096, 0, 4095, 1'b1, '{12'd0, 12'd0, 17'd65536, 16'd0}},
    '{2, 4096, 1, 4095, 1'b1, '{12'd1, 12'd1, 17'd65536, 16'd0}},
    '{4096, 4096, 1, 2047, 1'b0, '0}
  };

  linear_resample_weight_generator_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_target_index(in_target_index),
    .out_valid(out_valid),
    .out_near_index(out_near_index),
    .out_far_index(out_far_index),
    .out_near_weight(out_near_weight),
    .out_far_weight(out_far_weight),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned usable_length(input logic [LEN_W-1:0] v);
    if (v == '0) begin
      return 1;
    end
    if (v > LEN_W'(MAX_LENGTH)) begin
      return MAX_LENGTH;
    end
    return v;
  endfunction

  function automatic weights_t resample_weights(input logic [IDX_W-1:0] idx);
    longint unsigned s, t, o, top, num, den, span, near_i, far_i, frac;
    weights_t w;
    s = usable_length(src_len);
    t = usable_length(tgt_len);
    o = idx;
    top = s - 1;
    num = 0;
    den = 1;
    if (corner_mode) begin
      if (t > 1) begin
        num = o * top;
        den = t - 1;
      end
    end else begin
      span = (2 * o + 1) * s;
      den = 2 * t;
      num = (span > t) ? span - t : 0;
    end
    if (num >= top * den) begin
      near_i = top;
      frac = 0;
    end else begin
      near_i = num / den;
      frac = ((num % den) << FRAC_BITS) / den;
    end
    far_i = (near_i + 1 < top) ? near_i + 1 : top;
    w.near_index = near_i[IDX_W-1:0];
    w.far_index = far_i[IDX_W-1:0];
    w.near_weight = NW_W'((64'd1 << FRAC_BITS) - frac);
    w.far_weight = frac[FRAC_BITS-1:0];
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] pick_length();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 2);
      1: v = $urandom_range(4096, 8191);
      2, 3, 4: v = $urandom_range(1, 32);
      default: v = $urandom_range(1, 4096);
    endcase
    if ($urandom_range(0, 1)) begin
      v = v | ($urandom & 32'hFFFF_E000);
    end
    return v;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 4) == 0) begin
      return IDX_W'($urandom);
    end
    return IDX_W'($urandom_range(0, int'(usable_length(tgt_len)) - 1));
  endfunction

  // accepted requests are predicted, strobed results are checked
  always @(posedge clk) begin
    weights_t got, want;
    if (rst_n && start && !busy) begin
      if (use_literal) begin
        expected_weights.push_back(literal_weights);
      end else begin
        expected_weights.push_back(resample_weights(in_target_index));
      end
    end
    if (rst_n && out_valid) begin
      got = '{out_near_index, out_far_index, out_near_weight, out_far_weight};
      if (expected_weights.size() == 0) begin
        $error("unexpected result near_index %0d far_index %0d", got.near_index,
               got.far_index);
        errors++;
      end else begin
        want = expected_weights.pop_front();
        if (got.near_index !== want.near_index) begin
          $error("near_index expected %0d got %0d", want.near_index, got.near_index);
          errors++;
        end
        if (got.far_index !== want.far_index) begin
          $error("far_index expected %0d got %0d", want.far_index, got.far_index);
          errors++;
        end
        if (got.near_weight !== want.near_weight) begin
          $error("near_weight expected %0d got %0d", want.near_weight, got.near_weight);
          errors++;
        end
        if (got.far_weight !== want.far_weight) begin
          $error("far_weight expected %0d got %0d", want.far_weight, got.far_weight);
          errors++;
        end
      end
    end
  end

  task automatic send_request(input logic [IDX_W-1:0] idx, input int idle_pct,
                              input bit lit, input weights_t want);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_target_index <= idx;
    start <= 1'b1;
    use_literal <= lit;
    literal_weights <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (expected_weights.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_transfer(input lrw_reg_t r, input bit wr, input logic [DATA_W-1:0] data,
                              output logic [DATA_W-1:0] rd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_W'(4 * int'(r));
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_checked(input lrw_reg_t r, input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] rd, held;
    apb_transfer(r, 1'b1, data, rd);
    held = '0;
    case (r)
      REG_SOURCE_LENGTH: begin
        src_len = data[LEN_W-1:0];
        held = DATA_W'(src_len);
      end
      REG_TARGET_LENGTH: begin
        tgt_len = data[LEN_W-1:0];
        held = DATA_W'(tgt_len);
      end
      REG_CORNER_ALIGNED: begin
        corner_mode = data[0];
        held = DATA_W'(corner_mode);
      end
      default: begin
      end
    endcase
    if (r != REG_NONE) begin
      apb_transfer(r, 1'b0, '0, rd);
      if (rd !== held) begin
        $error("%s readback expected %0d got %0d", r.name(), held, rd);
        errors++;
      end
    end
  endtask

  task automatic load_setting(input logic [DATA_W-1:0] src, tgt, corner);
    write_checked(REG_SOURCE_LENGTH, src);
    write_checked(REG_TARGET_LENGTH, tgt);
    write_checked(REG_CORNER_ALIGNED, corner);
  endtask

  initial begin
    vector_t row;
    logic [DATA_W-1:0] src, tgt, corner;
    int pct;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unmapped address must leave the reset values alone
    write_checked(REG_NONE, '1);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.src[LEN_W-1:0] != src_len || row.tgt[LEN_W-1:0] != tgt_len ||
          row.corner[0] != corner_mode) begin
        drain();
        load_setting(row.src, row.tgt, row.corner);
      end
      send_request(row.index, 0, row.literal, row.want);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          src = 1;
          tgt = 4096;
          corner = 0;
        end
        1: begin
          src = 4096;
          tgt = 1;
          corner = 1;
        end
        2: begin
          src = 4096;
          tgt = 4096;
          corner = 0;
        end
        3: begin
          src = 32'hFFFF_FFFF;
          tgt = 32'hFFFF_E000;
          corner = 32'hFFFF_FFFE;
        end
        default: begin
          src = pick_length();
          tgt = pick_length();
          corner = $urandom;
        end
      endcase
      load_setting(src, tgt, corner);
      pct = idle_pct_by_phase[phase % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == PHASE_ITEMS / 2) begin
          drain();
        end
        send_request(pick_index(), pct, 1'b0, '0);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

>>> files.f
rtl/lrw_pkg.sv
rtl/lrw_front.sv
rtl/lrw_cell.sv
rtl/linear_resample_weight_generator_core.sv
tb/sv/testbench.sv
